// ----- src/bcdalu_pkg.sv -----
// Package for the BCD decimal ALU: sizes, operation and status codes, and the
// command and status structs that join the controller to the datapath.
// Depends on nothing; every other file of the block depends on it.
package bcdalu_pkg;

    localparam int DIGITS = 16;
    localparam int ND     = (DIGITS < 1) ? 1 : ((DIGITS > 16) ? 16 : DIGITS);
    localparam int DATA_W = 64;
    localparam int NIB_W  = 4;
    localparam int USED_W = ND * NIB_W;
    localparam int LANES  = 2 * ND;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int REL_W  = 2;
    localparam int NDC_W  = 5;

    // A lane holds up to ND digit products plus the incoming decimal carry.
    localparam int ACC_W  = $clog2(ND * 81 + ND * 9 + 10);
    localparam int POS_W  = $clog2(LANES);

    // Division by ten as a multiplication by a scaled reciprocal.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = (2 ** RECIP_SHIFT + 9) / 10;
    localparam int RECIP_W     = $clog2(RECIP + 1);

    typedef logic [NIB_W-1:0] digit_t;
    typedef logic [ACC_W-1:0] lane_t;
    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_INC = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } stat_t;

    typedef enum logic [REL_W-1:0] {
        REL_LESS    = 2'd0,
        REL_EQUAL   = 2'd1,
        REL_GREATER = 2'd2
    } rel_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic norm_step;
        logic emit;
        pos_t pos;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic is_mul;
    } dp_stat_t;

endpackage

// ----- src/bcdalu_cmd_if.sv -----
// Input channel of the BCD decimal ALU: valid/ready handshake and one item.
// Depends on bcdalu_pkg for the field widths.
interface bcdalu_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [bcdalu_pkg::OP_W-1:0]      opcode;
    logic [bcdalu_pkg::DATA_W-1:0]    operand_a;
    logic [bcdalu_pkg::DATA_W-1:0]    operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

// ----- src/bcdalu_rsp_if.sv -----
// Output channel of the BCD decimal ALU: valid/ready handshake and one result item.
// Depends on bcdalu_pkg for the field widths.
interface bcdalu_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bcdalu_pkg::DATA_W-1:0]    result;
    logic [bcdalu_pkg::STAT_W-1:0]    status;
    logic [bcdalu_pkg::REL_W-1:0]     relation;
    logic [bcdalu_pkg::NDC_W-1:0]     result_digits;

    modport source (output valid, output result, output status, output relation,
                    output result_digits, input ready);
    modport sink   (input valid, input result, input status, input relation,
                    input result_digits, output ready);
endinterface

// ----- src/bcdalu_datapath.sv -----
// Datapath of the BCD decimal ALU: operand registers, product lanes, the
// divide-by-ten digit unit and the output register. Depends on bcdalu_pkg.
module bcdalu_datapath (
    input  logic                            clk,
    input  logic [bcdalu_pkg::OP_W-1:0]     opcode,
    input  logic [bcdalu_pkg::DATA_W-1:0]   operand_a,
    input  logic [bcdalu_pkg::DATA_W-1:0]   operand_b,
    input  bcdalu_pkg::dp_cmd_t             cmd,
    output bcdalu_pkg::dp_stat_t            stat,
    output logic [bcdalu_pkg::DATA_W-1:0]   result,
    output logic [bcdalu_pkg::STAT_W-1:0]   status,
    output logic [bcdalu_pkg::REL_W-1:0]    relation,
    output logic [bcdalu_pkg::NDC_W-1:0]    result_digits
);
    import bcdalu_pkg::*;

    localparam int QP_W = ACC_W + RECIP_W;

    op_t                 op_reg;
    logic                bad_reg;
    rel_t                rel_reg;
    digit_t              a_reg [ND];
    digit_t              b_reg [ND];
    lane_t               lane_reg [LANES];
    lane_t               carry_reg;
    logic [USED_W-1:0]   res_reg;
    logic                ovf_reg;
    logic [NDC_W-1:0]    nd_reg;

    logic [DATA_W-1:0]   result_reg;
    stat_t               status_reg;
    rel_t                relation_reg;
    logic [NDC_W-1:0]    digits_reg;

    op_t                 in_op;
    digit_t              in_a [ND];
    digit_t              in_b [ND];
    logic                bad_a;
    logic                bad_b;
    logic                in_bad;
    rel_t                in_rel;
    lane_t               load_lane [LANES];
    lane_t               load_carry;
    lane_t               mul_lane [LANES];
    logic [7:0]          prod [ND];
    lane_t               t_sum;
    logic [QP_W-1:0]     q_prod;
    lane_t               quo;
    lane_t               rem;
    digit_t              dig;
    stat_t               fin_status;

    // Input decode: digits, validity and relation.
    always_comb
    begin
        in_op = op_t'(opcode);
        bad_a = 1'b0;
        bad_b = 1'b0;
        for (int i = 0; i < ND; i++)
        begin
            in_a[i] = operand_a[i*NIB_W +: NIB_W];
            in_b[i] = operand_b[i*NIB_W +: NIB_W];
            bad_a   = bad_a | (in_a[i] > 4'd9);
            bad_b   = bad_b | (in_b[i] > 4'd9);
        end
        in_bad = (in_op == OP_INC) ? bad_a : (bad_a | bad_b);
        if (operand_a[USED_W-1:0] < operand_b[USED_W-1:0])
            in_rel = REL_LESS;
        else if (operand_a[USED_W-1:0] == operand_b[USED_W-1:0])
            in_rel = REL_EQUAL;
        else
            in_rel = REL_GREATER;
        stat.is_mul = (in_op == OP_MUL);
        stat.skip   = in_bad || !(in_op == OP_ADD || in_op == OP_SUB ||
                                  in_op == OP_MUL || in_op == OP_INC);
    end

    // Lane contents at load. Subtraction adds the nines' complement of b and
    // a carry of one, so no carry out of the top digit means a is below b.
    always_comb
    begin
        load_carry = ((in_op == OP_SUB) || (in_op == OP_INC)) ? lane_t'(1) : '0;
        for (int k = 0; k < LANES; k++)
        begin
            load_lane[k] = '0;
            if (k < ND)
            begin
                unique case (in_op)
                    OP_ADD:  load_lane[k] = lane_t'(in_a[k]) + lane_t'(in_b[k]);
                    OP_SUB:  load_lane[k] = lane_t'(in_a[k]) + lane_t'(4'd9 - in_b[k]);
                    OP_INC:  load_lane[k] = lane_t'(in_a[k]);
                    default: load_lane[k] = '0;
                endcase
            end
        end
    end

    // One multiplier digit per step, most significant first: shift the lanes
    // up one decimal place and add the row of digit products.
    always_comb
    begin
        for (int k = 0; k < ND; k++)
            prod[k] = a_reg[k] * b_reg[ND-1];
        for (int k = 0; k < LANES; k++)
        begin
            mul_lane[k] = (k > 0) ? lane_reg[(k > 0) ? k - 1 : 0] : '0;
            if (k < ND)
                mul_lane[k] = mul_lane[k] + lane_t'(prod[(k < ND) ? k : 0]);
        end
    end

    // Digit unit: lowest lane plus carry, split into a digit and a new carry.
    always_comb
    begin
        t_sum  = lane_reg[0] + carry_reg;
        q_prod = QP_W'(t_sum) * QP_W'(RECIP);
        quo    = lane_t'(q_prod >> RECIP_SHIFT);
        rem    = t_sum - (quo << 3) - (quo << 1);
        dig    = rem[NIB_W-1:0];
    end

    always_comb
    begin
        if (bad_reg)
            fin_status = ST_INVALID;
        else
        begin
            unique case (op_reg)
                OP_ADD, OP_INC: fin_status = (carry_reg != '0) ? ST_OVERFLOW : ST_OK;
                OP_SUB:         fin_status = (carry_reg == '0) ? ST_UNDERFLOW : ST_OK;
                OP_MUL:         fin_status = ovf_reg ? ST_OVERFLOW : ST_OK;
                default:        fin_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            bad_reg   <= in_bad;
            rel_reg   <= in_rel;
            a_reg     <= in_a;
            b_reg     <= in_b;
            lane_reg  <= load_lane;
            carry_reg <= load_carry;
            res_reg   <= '0;
            ovf_reg   <= 1'b0;
            nd_reg    <= '0;
        end
        else if (cmd.mul_step)
        begin
            lane_reg <= mul_lane;
            for (int k = ND - 1; k > 0; k--)
                b_reg[k] <= b_reg[k-1];
            b_reg[0] <= '0;
        end
        else if (cmd.norm_step)
        begin
            for (int k = 0; k < LANES - 1; k++)
                lane_reg[k] <= lane_reg[k+1];
            lane_reg[LANES-1] <= '0;
            carry_reg <= quo;
            if (cmd.pos < POS_W'(ND))
            begin
                res_reg <= (res_reg >> NIB_W) | (USED_W'(dig) << (USED_W - NIB_W));
                if (dig != '0)
                    nd_reg <= NDC_W'(cmd.pos) + NDC_W'(1);
            end
            else if (dig != '0)
                ovf_reg <= 1'b1;
        end

        if (cmd.emit)
        begin
            result_reg   <= DATA_W'(res_reg);
            status_reg   <= fin_status;
            relation_reg <= rel_reg;
            digits_reg   <= nd_reg;
        end
    end

    assign result        = result_reg;
    assign status        = status_reg;
    assign relation      = relation_reg;
    assign result_digits = digits_reg;

endmodule

// ----- src/bcdalu_ctrl.sv -----
// Controller of the BCD decimal ALU: state machine, digit position counter
// and output valid flag. Depends on bcdalu_pkg.
module bcdalu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    output bcdalu_pkg::dp_cmd_t   cmd,
    input  bcdalu_pkg::dp_stat_t  stat
);
    import bcdalu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_NORM = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg,     state_next;
    pos_t   cnt_reg,       cnt_next;
    logic   mul_reg,       mul_next;
    logic   out_valid_reg, out_valid_next;
    pos_t   last_pos;

    assign last_pos = mul_reg ? POS_W'(LANES - 1) : POS_W'(ND - 1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mul_next       = mul_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.pos        = cnt_reg;
        in_ready       = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    mul_next = stat.is_mul;
                    if (stat.skip)
                        state_next = S_DONE;
                    else if (stat.is_mul)
                        state_next = S_MUL;
                    else
                        state_next = S_NORM;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == POS_W'(ND - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_NORM;
                end
                else
                    cnt_next = cnt_reg + POS_W'(1);
            end
            S_NORM:
            begin
                cmd.norm_step = 1'b1;
                if (cnt_reg == last_pos)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + POS_W'(1);
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            mul_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mul_reg       <= mul_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_skip_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && stat.skip) |=> (state_reg == S_DONE))
        else $error("item with nothing to compute did not go straight to done");

    a_mul_to_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && cnt_reg == POS_W'(ND - 1))
        |=> (state_reg == S_NORM && cnt_reg == '0))
        else $error("multiply rows did not hand over to digit normalisation");

    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NORM) |-> (cnt_reg <= last_pos))
        else $error("digit position ran past the last place");

    a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("emitted result did not reach the output register");

endmodule

// ----- src/bcd_decimal_alu.sv -----
// Compare, unknown operation codes and items with an invalid digit skip the digit walk; add, subtract
// and increment walk the DIGITS low places; multiply runs DIGITS multiply rows, then walks all 2*DIGITS places.
// One item at a time: a new item can be taken in the cycle after the result is loaded, and the
// walk handles one BCD digit position per cycle through the divide-by-ten unit.
// The output register holds a result while a further item is taken and worked on.
// Asynchronous active-low reset empties the controller and its output valid flag; the datapath is not reset.
module bcd_decimal_alu (
    input  logic          clk,
    input  logic          rst_n,
    bcdalu_cmd_if.sink    cmd,
    bcdalu_rsp_if.source  rsp
);
    import bcdalu_pkg::*;

    // The controller owns sequencing: it loads an item, for a multiply runs
    // its rows (one multiplier digit per cycle, most significant first), then
    // walks the lanes one decimal place per cycle to resolve carries, and
    // finally loads the output register when it is free.
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    bcdalu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // The datapath keeps the operands, a row of lanes of twice the digit
    // count and the digit unit. Add, subtract and increment preload the
    // lanes with digit sums and share the same carry walk as multiply, whose
    // upper half of the walk only detects overflow.
    bcdalu_datapath u_datapath (
        .clk           (clk),
        .opcode        (cmd.opcode),
        .operand_a     (cmd.operand_a),
        .operand_b     (cmd.operand_b),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .result        (rsp.result),
        .status        (rsp.status),
        .relation      (rsp.relation),
        .result_digits (rsp.result_digits)
    );

endmodule
